/* hdl/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the line fragment reassembler.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam int MAX_PIXELS    = 4096;
	localparam int MAX_FRAGMENTS = 16;
	localparam int PIX_AW        = $clog2(MAX_PIXELS);
	localparam int FRAG_W        = $clog2(MAX_FRAGMENTS);
	localparam int COUNT_W       = $clog2(MAX_FRAGMENTS + 1);
	localparam int CQ_DEPTH      = 4;
	localparam int CQ_PW         = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH      = 4;
	localparam int RQ_PW         = $clog2(RQ_DEPTH);

	typedef enum logic [2:0] {
		ST_WRITTEN = 3'd0,
		ST_DUP     = 3'd1,
		ST_IGNORED = 3'd2,
		ST_RANGE   = 3'd3,
		ST_READ    = 3'd4
	} lfr_status_t;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_IGNORE = 2'd1,
		CMD_WRITE  = 2'd2
	} lfr_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  packet_type;
		logic [31:0] line_id;
		logic [7:0]  frag_idx;
		logic [12:0] frag_len;
		logic [7:0]  frag_total;
		logic [11:0] pixel_index;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic        last_flag;
		logic [11:0] read_index;
	} lfr_in_t;

	typedef struct packed {
		lfr_status_t status;
		logic        line_complete;
		logic        line_ready;
		logic [31:0] completed_line_id;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
	} lfr_out_t;

	// classified item handed from front to back
	typedef struct packed {
		lfr_kind_t         kind;
		logic              range_bad;
		logic              rd_oob;
		logic [FRAG_W-1:0] frag;
		logic [31:0]       line_id;
		logic [7:0]        total;
		logic              last;
		logic [23:0]       rgb;
		logic [PIX_AW-1:0] addr;
	} lfr_cmd_t;

endpackage

/* hdl/lfr_front.sv */
// ----------------------------------------------------------------------------
// lfr_front
// Accepts items, holds the packet type register and classifies each item.
// ----------------------------------------------------------------------------
module lfr_front import lfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  logic     full,
	input  lfr_in_t  req,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [7:0] cfg_data,
	output logic     cmd_push,
	output lfr_cmd_t cmd
);

	logic [7:0]  exp_type_q;
	logic [20:0] prod;
	logic [21:0] offset;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_type_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			exp_type_q <= cfg_data;
		end
	end

	assign cmd_push = push && !full;
	assign prod     = 21'(req.frag_idx) * 21'(req.frag_len);
	assign offset   = 22'(prod) + 22'(req.pixel_index);

	always_comb begin
		cmd.range_bad = (32'(req.frag_idx) >= MAX_FRAGMENTS)
			|| ({1'b0, req.pixel_index} >= req.frag_len)
			|| (32'(offset) >= MAX_PIXELS);
		cmd.rd_oob  = 32'(req.read_index) >= MAX_PIXELS;
		cmd.frag    = FRAG_W'(req.frag_idx);
		cmd.line_id = req.line_id;
		cmd.total   = req.frag_total;
		cmd.last    = req.last_flag;
		cmd.rgb     = {req.red_in, req.green_in, req.blue_in};
		if (req.req_type) begin
			cmd.kind = CMD_READ;
			cmd.addr = PIX_AW'(req.read_index);
		end else if (req.packet_type != exp_type_q) begin
			cmd.kind = CMD_IGNORE;
			cmd.addr = PIX_AW'(offset);
		end else begin
			cmd.kind = CMD_WRITE;
			cmd.addr = PIX_AW'(offset);
		end
	end

endmodule

/* hdl/lfr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// lfr_cmd_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lfr_cmd_queue import lfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  lfr_cmd_t wdata,
	input  logic     rd,
	output lfr_cmd_t rdata,
	output logic     full,
	output logic     empty
);

	lfr_cmd_t         store_q [CQ_DEPTH];
	logic [CQ_PW-1:0] wr_ptr_q;
	logic [CQ_PW-1:0] rd_ptr_q;
	logic [CQ_PW:0]   count_q;

	assign full  = 32'(count_q) == CQ_DEPTH;
	assign empty = count_q == '0;
	assign rdata = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/lfr_res_queue.sv */
// ----------------------------------------------------------------------------
// lfr_res_queue
// Result queue that parts the back end from the consumer.
// ----------------------------------------------------------------------------
module lfr_res_queue import lfr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  lfr_out_t       wdata,
	input  logic           rd,
	output lfr_out_t       rdata,
	output logic           full,
	output logic           empty,
	output logic [RQ_PW:0] count
);

	lfr_out_t         store_q [RQ_DEPTH];
	logic [RQ_PW-1:0] wr_ptr_q;
	logic [RQ_PW-1:0] rd_ptr_q;
	logic [RQ_PW:0]   count_q;

	assign full  = 32'(count_q) == RQ_DEPTH;
	assign empty = count_q == '0;
	assign count = count_q;
	assign rdata = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/lfr_back.sv */
// ----------------------------------------------------------------------------
// lfr_back
// Line bookkeeping, double-banked pixel memory and result stage.
// ----------------------------------------------------------------------------
module lfr_back import lfr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  lfr_cmd_t       cmd,
	output logic           cmd_pop,
	input  logic [RQ_PW:0] res_count,
	output logic           res_push,
	output lfr_out_t       res
);

	logic [23:0] mem [2*MAX_PIXELS];
	logic [23:0] rdata_s2;

	logic                     fill_sel_q;
	logic [MAX_FRAGMENTS-1:0] map_q;
	logic [COUNT_W-1:0]       count_q;
	logic [31:0]              cur_line_q;
	logic [31:0]              done_line_q;
	logic                     done_flag_q;
	logic                     ready_q;

	logic                     fill_sel_n;
	logic [MAX_FRAGMENTS-1:0] map_n;
	logic [COUNT_W-1:0]       count_n;
	logic [31:0]              cur_line_n;
	logic [31:0]              done_line_n;
	logic                     done_flag_n;
	logic                     ready_n;
	lfr_status_t              status;
	logic                     complete;
	logic                     we;
	logic [PIX_AW:0]          mem_addr;

	logic        valid_s2;
	lfr_out_t    res_s2;
	logic        show_pix_s2;

	// issue only with room guaranteed in the result queue
	assign cmd_pop = !cmd_empty && ((32'(res_count) + 32'(valid_s2)) < RQ_DEPTH);

	always_comb begin
		fill_sel_n  = fill_sel_q;
		map_n       = map_q;
		count_n     = count_q;
		cur_line_n  = cur_line_q;
		done_line_n = done_line_q;
		done_flag_n = done_flag_q;
		ready_n     = ready_q;
		status      = ST_IGNORED;
		complete    = 1'b0;
		we          = 1'b0;
		mem_addr    = {fill_sel_q, cmd.addr};
		case (cmd.kind)
			CMD_READ: begin
				status   = ST_READ;
				mem_addr = {~fill_sel_q, cmd.addr};
				if (cmd.last) begin
					ready_n = 1'b0;
				end
			end
			CMD_WRITE: begin
				// a new line id restarts the fragment bookkeeping
				if (cmd.line_id != cur_line_q) begin
					cur_line_n  = cmd.line_id;
					map_n       = '0;
					count_n     = '0;
					done_flag_n = 1'b0;
				end
				if (cmd.range_bad) begin
					status = ST_RANGE;
				end else if (map_n[cmd.frag]) begin
					status = ST_DUP;
				end else begin
					status = ST_WRITTEN;
					we     = 1'b1;
					if (cmd.last) begin
						map_n[cmd.frag] = 1'b1;
						count_n         = count_n + 1'b1;
						if ((32'(count_n) == 32'(cmd.total)) && !done_flag_n) begin
							fill_sel_n  = ~fill_sel_q;
							ready_n     = 1'b1;
							done_line_n = cur_line_n;
							done_flag_n = 1'b1;
							complete    = 1'b1;
						end
					end
				end
			end
			default: begin
				status = ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_sel_q  <= 1'b0;
			map_q       <= '0;
			count_q     <= '0;
			cur_line_q  <= '0;
			done_line_q <= '0;
			done_flag_q <= 1'b0;
			ready_q     <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			valid_s2 <= cmd_pop;
			if (cmd_pop) begin
				fill_sel_q  <= fill_sel_n;
				map_q       <= map_n;
				count_q     <= count_n;
				cur_line_q  <= cur_line_n;
				done_line_q <= done_line_n;
				done_flag_q <= done_flag_n;
				ready_q     <= ready_n;
			end
		end
	end

	// pixel memory, one access per item
	always_ff @(posedge clk) begin
		if (cmd_pop && we) begin
			mem[mem_addr] <= cmd.rgb;
		end
		rdata_s2 <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_s2.status            <= status;
			res_s2.line_complete     <= complete;
			res_s2.line_ready        <= ready_n;
			res_s2.completed_line_id <= done_line_n;
			res_s2.red_out           <= '0;
			res_s2.green_out         <= '0;
			res_s2.blue_out          <= '0;
			show_pix_s2              <= (cmd.kind == CMD_READ) && !cmd.rd_oob;
		end
	end

	always_comb begin
		res = res_s2;
		if (show_pix_s2) begin
			res.red_out   = rdata_s2[23:16];
			res.green_out = rdata_s2[15:8];
			res.blue_out  = rdata_s2[7:0];
		end
	end

	assign res_push = valid_s2;

endmodule

/* hdl/line_fragment_reassembler.sv */
// ----------------------------------------------------------------------------
// line_fragment_reassembler
// Rebuilds image lines from out-of-order pixel fragments in a double bank.
// ----------------------------------------------------------------------------
// Both sides look like a queue: push an item while full is low, pop a result
// while empty is low, one result per item in item order. Throughput is one
// item per clock while the result queue has room; each item makes exactly one
// access to the single-ported pixel memory and one update of the line
// bookkeeping registers, which set that figure. A result passes the item
// queue, the registered bookkeeping update and memory read, and the result
// queue. The packet type register is written over the cfg channel, which
// is always ready; the user must write it only while idle; nothing checks it.
module line_fragment_reassembler import lfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  lfr_in_t    req,
	output logic       empty,
	input  logic       pop,
	output lfr_out_t   rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	// front to queue
	logic     cmd_push;
	lfr_cmd_t cmd_in;

	// queue to back
	logic     cmd_pop;
	logic     cmd_empty;
	lfr_cmd_t cmd_out;

	// back to result queue
	logic           res_push;
	lfr_out_t       res;
	logic           res_full;
	logic [RQ_PW:0] res_count;

	// classify: type check, pixel offset and range check
	lfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	// decouples acceptance from the back end
	lfr_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.full   (full),
		.empty  (cmd_empty)
	);

	// fragment map, bank swap, pixel memory
	lfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res)
	);

	// finished results wait here for the consumer
	lfr_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res),
		.rd     (pop && !empty),
		.rdata  (rsp),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

`ifndef SYNTHESIS
	// issue credit must keep the result queue from overflowing
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue overflow");

	// a completing item always leaves the line ready
	a_complete_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.line_complete) |-> rsp.line_ready)
		else $error("line complete without line ready");

	// only reads carry pixel data
	a_write_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != ST_READ)
		|-> (rsp.red_out == '0 && rsp.green_out == '0 && rsp.blue_out == '0))
		else $error("pixel data on a non-read result");
`endif

endmodule
